/* design/ofov_pkg.sv */
// Shared types, constants and the control-store program of the optical-flow
// velocity block. No dependencies; imported by ofov_dp and the top level.
package ofov_pkg;

    // Field and datapath widths
    localparam int DATA_W   = 32;              // config data, flow and gyro words
    localparam int CFG_IDX_W = 3;              // config register index
    localparam int DT_W     = 22;              // time step when accepted (<= limit)
    localparam int DEN_W    = DT_W + 8;        // divisor dt*256
    localparam int MUL_W    = DATA_W + 1;      // multiplier operand, signed
    localparam int PROD_W   = 2 * MUL_W;       // multiplier product
    localparam int ACC_W    = 2 * DATA_W + 1;  // sum of two Q.24 products
    localparam int NUM_W    = 84;              // |sum| * 1e6
    localparam int QUO_W    = 41;              // quotient bits kept
    localparam int SUM_W    = QUO_W + 2;       // signed flow + yaw
    localparam int YAW_W    = 40;              // yaw term after the 2^24 scale
    localparam int YAW_SHIFT = 24;
    localparam int CNT_W    = $clog2(QUO_W);
    localparam int PC_W     = 5;

    localparam logic [MUL_W-1:0] US_PER_S = MUL_W'(1000000);

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XX      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XY      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_XZ      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YX      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_YZ      = 3'd6;

    // Config reset values
    localparam logic [DT_W-1:0]   MAX_INTERVAL_RST = DT_W'(40000);
    localparam logic [DATA_W-1:0] COEF_ONE         = DATA_W'(32'h0100_0000);

    // Result status
    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_PREV = 2'd1,
        ST_ZERO_DT = 2'd2,
        ST_LONG_DT = 2'd3
    } t_status;

    // Extrinsic matrix rows, Q8.24
    typedef struct packed {
        logic [DATA_W-1:0] xx;
        logic [DATA_W-1:0] xy;
        logic [DATA_W-1:0] xz;
        logic [DATA_W-1:0] yx;
        logic [DATA_W-1:0] yy;
        logic [DATA_W-1:0] yz;
    } t_coefs;

    // Control word fields
    typedef enum logic [2:0] {
        MS_NONE, MS_A_DX, MS_B_DY, MS_G_GZ, MS_MLO_K, MS_MHI_K
    } t_mul_sel;

    typedef enum logic [1:0] {
        AC_NONE, AC_LOAD, AC_ADD, AC_ABS
    } t_acc_op;

    typedef enum logic [1:0] {
        NM_NONE, NM_LOAD_LO, NM_ADD_HI
    } t_num_op;

    typedef enum logic [1:0] {
        DV_NONE, DV_INIT, DV_STEP
    } t_div_op;

    typedef enum logic [1:0] {
        BR_NEXT, BR_LOOP, BR_END
    } t_branch;

    typedef struct packed {
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        logic     yaw_ld;
        t_num_op  num_op;
        logic     lane;     // 0 = X row, 1 = Y row
        t_div_op  div_op;
        t_branch  br;
    } t_uword;

    localparam t_uword UW_NOP = '{
        mul_sel: MS_NONE, acc_op: AC_NONE, yaw_ld: 1'b0, num_op: NM_NONE,
        lane: 1'b0, div_op: DV_NONE, br: BR_END
    };

    // Program layout
    localparam logic [PC_W-1:0] PC_FIRST      = 5'd0;
    localparam logic [PC_W-1:0] PC_LANE_STEPS = 5'd7;
    localparam logic [PC_W-1:0] PC_DIV_INIT   = 5'd14;
    localparam logic [PC_W-1:0] PC_DIV_LOOP   = 5'd15;
    localparam logic [PC_W-1:0] PC_FIN        = 5'd16;

    // Control store. Each row runs the same seven steps; each multiply's
    // product is registered before it is used.
    function automatic t_uword uc_rom(input logic [PC_W-1:0] pc);
        t_uword          w;
        logic            lane;
        logic [PC_W-1:0] sub;
        w    = UW_NOP;
        lane = (pc >= PC_LANE_STEPS);
        sub  = lane ? pc - PC_LANE_STEPS : pc;
        if (pc < PC_DIV_INIT) begin
            w.lane = lane;
            w.br   = BR_NEXT;
            case (sub)
                5'd0: begin
                    w.mul_sel = MS_A_DX;
                end
                5'd1: begin
                    w.mul_sel = MS_B_DY;
                    w.acc_op  = AC_LOAD;
                end
                5'd2: begin
                    w.mul_sel = MS_G_GZ;
                    w.acc_op  = AC_ADD;
                end
                5'd3: begin
                    w.yaw_ld  = 1'b1;
                    w.acc_op  = AC_ABS;
                end
                5'd4: begin
                    w.mul_sel = MS_MLO_K;
                end
                5'd5: begin
                    w.mul_sel = MS_MHI_K;
                    w.num_op  = NM_LOAD_LO;
                end
                5'd6: begin
                    w.num_op  = NM_ADD_HI;
                end
                default: begin
                    w.br = BR_END;
                end
            endcase
        end else begin
            case (pc)
                PC_DIV_INIT: begin
                    w.div_op = DV_INIT;
                    w.br     = BR_NEXT;
                end
                PC_DIV_LOOP: begin
                    w.div_op = DV_STEP;
                    w.br     = BR_LOOP;
                end
                default: begin
                    w.br = BR_END;
                end
            endcase
        end
        return w;
    endfunction

endpackage

/* design/ofov_dp.sv */
// Datapath of the optical-flow velocity block: shared 33x33 multiplier,
// accumulator, per-row numerators, two-lane restoring divider and output combine.
// Depends on ofov_pkg.
module ofov_dp (
    input  logic                           i_clk,
    input  ofov_pkg::t_uword               i_uw,
    input  ofov_pkg::t_coefs               i_coef,
    input  logic [ofov_pkg::DATA_W-1:0]    i_dx,
    input  logic [ofov_pkg::DATA_W-1:0]    i_dy,
    input  logic [ofov_pkg::DATA_W-1:0]    i_gz,
    input  logic [ofov_pkg::DT_W-1:0]      i_dt,
    output logic [ofov_pkg::DATA_W-1:0]    o_vel_x,
    output logic [ofov_pkg::DATA_W-1:0]    o_vel_y
);
    import ofov_pkg::*;

    localparam logic [PROD_W-1:0] YAW_RND = PROD_W'((64'd1 << YAW_SHIFT) - 64'd1);
    localparam int NUM_LO_W = NUM_W - DATA_W;

    // One restoring step: returns {quotient bit, new remainder}
    function automatic logic [DEN_W:0] div_step(input logic [DEN_W-1:0] rem,
                                                input logic             bit_in,
                                                input logic [DEN_W-1:0] den);
        logic [DEN_W:0] t;
        logic [DEN_W:0] d;
        t = {rem, bit_in};
        d = t - {1'b0, den};
        if (t >= {1'b0, den}) begin
            div_step = {1'b1, d[DEN_W-1:0]};
        end else begin
            div_step = {1'b0, t[DEN_W-1:0]};
        end
    endfunction

    // Cap flow at 2^40, apply sign, add yaw, saturate to 32 bits
    function automatic logic [DATA_W-1:0] combine(input logic             ovf,
                                                  input logic [QUO_W-1:0] q,
                                                  input logic             neg,
                                                  input logic [YAW_W-1:0] yaw);
        logic [QUO_W-1:0] f;
        logic [QUO_W:0]   mag;
        logic [QUO_W:0]   flow;
        logic [SUM_W-1:0] s;
        f    = (ovf || q[QUO_W-1]) ? {1'b1, {(QUO_W-1){1'b0}}} : q;
        mag  = {1'b0, f};
        flow = neg ? (QUO_W+1)'(0) - mag : mag;
        s    = {flow[QUO_W], flow} + {{(SUM_W-YAW_W){yaw[YAW_W-1]}}, yaw};
        if ((&s[SUM_W-1:DATA_W-1]) || (~|s[SUM_W-1:DATA_W-1])) begin
            combine = s[DATA_W-1:0];
        end else if (s[SUM_W-1]) begin
            combine = {1'b1, {(DATA_W-1){1'b0}}};
        end else begin
            combine = {1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    logic [DATA_W-1:0]        coef_a;
    logic [DATA_W-1:0]        coef_b;
    logic [DATA_W-1:0]        coef_g;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] prod_c;
    logic [PROD_W-1:0]        yaw_adj;
    logic [DEN_W-1:0]         den;
    logic [DEN_W:0]           step_x;
    logic [DEN_W:0]           step_y;

    logic [PROD_W-1:0] r_prod;
    logic [ACC_W-1:0]  r_acc;
    logic              r_neg_x, r_neg_y;
    logic [YAW_W-1:0]  r_yaw_x, r_yaw_y;
    logic [NUM_W-1:0]  r_num_x, r_num_y;
    logic              r_ovf_x, r_ovf_y;
    logic [DEN_W-1:0]  r_rem_x, r_rem_y;
    logic [QUO_W-1:0]  r_nq_x, r_nq_y;

    // Row coefficients for the lane in work
    assign coef_a = i_uw.lane ? i_coef.yx : i_coef.xx;
    assign coef_b = i_uw.lane ? i_coef.yy : i_coef.xy;
    assign coef_g = i_uw.lane ? i_coef.yz : i_coef.xz;

    // Multiplier operand select
    always_comb begin
        case (i_uw.mul_sel)
            MS_A_DX: begin
                mul_a = {coef_a[DATA_W-1], coef_a};
                mul_b = {i_dx[DATA_W-1], i_dx};
            end
            MS_B_DY: begin
                mul_a = {coef_b[DATA_W-1], coef_b};
                mul_b = {i_dy[DATA_W-1], i_dy};
            end
            MS_G_GZ: begin
                mul_a = {coef_g[DATA_W-1], coef_g};
                mul_b = {i_gz[DATA_W-1], i_gz};
            end
            MS_MLO_K: begin
                mul_a = {1'b0, r_acc[DATA_W-1:0]};
                mul_b = US_PER_S;
            end
            MS_MHI_K: begin
                mul_a = {1'b0, r_acc[2*DATA_W-1:DATA_W]};
                mul_b = US_PER_S;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_c = mul_a * mul_b;

    // Yaw term, truncated toward zero
    assign yaw_adj = r_prod + (r_prod[PROD_W-1] ? YAW_RND : '0);

    // Divider: dt*256
    assign den    = {i_dt, 8'd0};
    assign step_x = div_step(r_rem_x, r_nq_x[QUO_W-1], den);
    assign step_y = div_step(r_rem_y, r_nq_y[QUO_W-1], den);

    // Multiply, accumulate and per-row holding registers
    always_ff @(posedge i_clk) begin
        r_prod <= prod_c;

        case (i_uw.acc_op)
            AC_LOAD: r_acc <= r_prod[ACC_W-1:0];
            AC_ADD:  r_acc <= r_acc + r_prod[ACC_W-1:0];
            AC_ABS:  r_acc <= r_acc[ACC_W-1] ? ACC_W'(0) - r_acc : r_acc;
            default: ;
        endcase

        if (i_uw.acc_op == AC_ABS) begin
            if (i_uw.lane) begin
                r_neg_y <= r_acc[ACC_W-1];
            end else begin
                r_neg_x <= r_acc[ACC_W-1];
            end
        end

        if (i_uw.yaw_ld) begin
            if (i_uw.lane) begin
                r_yaw_y <= yaw_adj[YAW_SHIFT+YAW_W-1:YAW_SHIFT];
            end else begin
                r_yaw_x <= yaw_adj[YAW_SHIFT+YAW_W-1:YAW_SHIFT];
            end
        end

        // numerator = lo*1e6 + (hi*1e6 << 32)
        case (i_uw.num_op)
            NM_LOAD_LO: begin
                if (i_uw.lane) begin
                    r_num_y <= {{DATA_W{1'b0}}, r_prod[NUM_LO_W-1:0]};
                end else begin
                    r_num_x <= {{DATA_W{1'b0}}, r_prod[NUM_LO_W-1:0]};
                end
            end
            NM_ADD_HI: begin
                if (i_uw.lane) begin
                    r_num_y <= {r_num_y[NUM_W-1:DATA_W] + r_prod[NUM_LO_W-1:0],
                                r_num_y[DATA_W-1:0]};
                end else begin
                    r_num_x <= {r_num_x[NUM_W-1:DATA_W] + r_prod[NUM_LO_W-1:0],
                                r_num_x[DATA_W-1:0]};
                end
            end
            default: ;
        endcase
    end

    // Two-lane restoring divider, one quotient bit per cycle per lane
    always_ff @(posedge i_clk) begin
        case (i_uw.div_op)
            DV_INIT: begin
                r_ovf_x <= r_num_x[NUM_W-1:QUO_W] >=
                           {{(NUM_W-QUO_W-DEN_W){1'b0}}, den};
                r_ovf_y <= r_num_y[NUM_W-1:QUO_W] >=
                           {{(NUM_W-QUO_W-DEN_W){1'b0}}, den};
                r_rem_x <= r_num_x[QUO_W+DEN_W-1:QUO_W];
                r_rem_y <= r_num_y[QUO_W+DEN_W-1:QUO_W];
                r_nq_x  <= r_num_x[QUO_W-1:0];
                r_nq_y  <= r_num_y[QUO_W-1:0];
            end
            DV_STEP: begin
                r_rem_x <= step_x[DEN_W-1:0];
                r_rem_y <= step_y[DEN_W-1:0];
                r_nq_x  <= {r_nq_x[QUO_W-2:0], step_x[DEN_W]};
                r_nq_y  <= {r_nq_y[QUO_W-2:0], step_y[DEN_W]};
            end
            default: ;
        endcase
    end

    assign o_vel_x = combine(r_ovf_x, r_nq_x, r_neg_x, r_yaw_x);
    assign o_vel_y = combine(r_ovf_y, r_nq_y, r_neg_y, r_yaw_y);

endmodule

/* design/optical_flow_to_odometry_velocity.sv */
// Optical-flow to odometry velocity, top level: config registers, sample
// history, status check, control-store sequencer and output register.
// Sequence: a rejected sample goes straight to the load of the output register; an accepted
// one first runs 14 multiply/accumulate steps on one shared 33x33 multiplier, divider setup
// and 41 divider steps.
// One sample is in work at a time: the input is stalled until the output register is loaded,
// and that load waits while the output word is stalled.
// Reset (i_rst_n low, synchronous) clears the history and loads default config.
// Depends on ofov_pkg and ofov_dp.
module optical_flow_to_odometry_velocity (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample input
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ofov_pkg::DATA_W-1:0]        i_time_us,
    input  logic signed [ofov_pkg::DATA_W-1:0] i_sum_x,
    input  logic signed [ofov_pkg::DATA_W-1:0] i_sum_y,
    input  logic signed [ofov_pkg::DATA_W-1:0] i_gyro_z,
    // result output
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [1:0]                         o_status,
    output logic signed [ofov_pkg::DATA_W-1:0] o_vel_x,
    output logic signed [ofov_pkg::DATA_W-1:0] o_vel_y,
    // config write port
    input  logic                               i_cfg_we,
    input  logic [ofov_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ofov_pkg::DATA_W-1:0]        i_cfg_data
);
    import ofov_pkg::*;

    typedef enum logic [1:0] {
        SQ_IDLE = 2'b01,
        SQ_RUN  = 2'b10
    } t_seq;

    logic              in_acc;
    logic [DATA_W-1:0] dt32;
    t_status           n_status;
    t_uword            uw;
    t_uword            dp_uw;
    logic              run;
    logic              out_free;
    logic              fin;
    logic [DATA_W-1:0] dp_vel_x;
    logic [DATA_W-1:0] dp_vel_y;

    logic [DT_W-1:0]   r_max_int;
    t_coefs            r_coef;
    logic [DATA_W-1:0] r_prev_time;
    logic [DATA_W-1:0] r_prev_x;
    logic [DATA_W-1:0] r_prev_y;
    logic              r_have;
    logic [DATA_W-1:0] r_dx;
    logic [DATA_W-1:0] r_dy;
    logic [DATA_W-1:0] r_gz;
    logic [DT_W-1:0]   r_dt;
    t_status           r_status;
    t_seq              r_seq;
    logic [PC_W-1:0]   r_pc;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_out_valid;
    t_status           r_out_status;
    logic [DATA_W-1:0] r_out_vx;
    logic [DATA_W-1:0] r_out_vy;

    assign run        = (r_seq == SQ_RUN);
    assign o_in_stall = run;
    assign in_acc     = i_in_valid && !o_in_stall;

    // Sample check against the stored history
    assign dt32 = i_time_us - r_prev_time;
    always_comb begin
        if (!r_have) begin
            n_status = ST_NO_PREV;
        end else if (dt32 == '0) begin
            n_status = ST_ZERO_DT;
        end else if (dt32 > {{(DATA_W-DT_W){1'b0}}, r_max_int}) begin
            n_status = ST_LONG_DT;
        end else begin
            n_status = ST_OK;
        end
    end

    // Control store fetch
    assign uw       = uc_rom(r_pc);
    assign dp_uw    = run ? uw : UW_NOP;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fin      = run && (uw.br == BR_END) && out_free;

    // Config, history and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_int   <= MAX_INTERVAL_RST;
            r_coef      <= '{xx: COEF_ONE, xy: '0, xz: '0, yx: '0, yy: COEF_ONE, yz: '0};
            r_prev_time <= '0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_have      <= 1'b0;
            r_seq       <= SQ_IDLE;
            r_pc        <= PC_FIRST;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_MAX_INTERVAL: r_max_int <= i_cfg_data[DT_W-1:0];
                    CFG_COEF_XX:      r_coef.xx <= i_cfg_data;
                    CFG_COEF_XY:      r_coef.xy <= i_cfg_data;
                    CFG_COEF_XZ:      r_coef.xz <= i_cfg_data;
                    CFG_COEF_YX:      r_coef.yx <= i_cfg_data;
                    CFG_COEF_YY:      r_coef.yy <= i_cfg_data;
                    CFG_COEF_YZ:      r_coef.yz <= i_cfg_data;
                    default: ;
                endcase
            end

            // every accepted sample becomes the history, whatever its status
            if (in_acc) begin
                r_prev_time <= i_time_us;
                r_prev_x    <= i_sum_x;
                r_prev_y    <= i_sum_y;
                r_have      <= 1'b1;
                r_seq       <= SQ_RUN;
                r_pc        <= (n_status == ST_OK) ? PC_FIRST : PC_FIN;
            end

            if (run) begin
                case (uw.br)
                    BR_NEXT: r_pc <= r_pc + 1'b1;
                    BR_LOOP: begin
                        if (r_cnt == '0) begin
                            r_pc <= r_pc + 1'b1;
                        end else begin
                            r_cnt <= r_cnt - 1'b1;
                        end
                    end
                    BR_END: begin
                        if (out_free) begin
                            r_seq <= SQ_IDLE;
                        end
                    end
                    default: ;
                endcase
                if (uw.div_op == DV_INIT) begin
                    r_cnt <= CNT_W'(QUO_W - 1);
                end
            end

            // output word handshake
            if (fin) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured sample terms and output word
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_dx     <= i_sum_x - r_prev_x;
            r_dy     <= i_sum_y - r_prev_y;
            r_gz     <= i_gyro_z;
            r_dt     <= dt32[DT_W-1:0];
            r_status <= n_status;
        end
        if (fin) begin
            r_out_status <= r_status;
            r_out_vx     <= (r_status == ST_OK) ? dp_vel_x : '0;
            r_out_vy     <= (r_status == ST_OK) ? dp_vel_y : '0;
        end
    end

    ofov_dp u_dp (
        .i_clk   (i_clk),
        .i_uw    (dp_uw),
        .i_coef  (r_coef),
        .i_dx    (r_dx),
        .i_dy    (r_dy),
        .i_gz    (r_gz),
        .i_dt    (r_dt),
        .o_vel_x (dp_vel_x),
        .o_vel_y (dp_vel_y)
    );

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_vel_x     = r_out_vx;
    assign o_vel_y     = r_out_vy;

endmodule
